// File: rtl/core/tlv_pkg.sv
// Shared types and constants for the TLV stream parser.
`default_nettype none

package tlv_pkg;

    // Parser phase within one TLV item.
    typedef enum logic [2:0] {
        PH_TAG,
        PH_TAG2,
        PH_LEN,
        PH_LEN1,
        PH_LENHI,
        PH_LENLO,
        PH_VALUE,
        PH_DRAIN
    } phase_t;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_VALUE,
        KIND_TRUNC,
        KIND_BADLEN
    } kind_t;

    // Padding bytes that may stand where a tag is expected.
    localparam logic [7:0] PAD_ZERO = 8'h00;
    localparam logic [7:0] PAD_ONES = 8'hFF;

    // Length bytes with a special meaning.
    localparam logic [7:0] LEN_ONE_BYTE  = 8'h81;
    localparam logic [7:0] LEN_TWO_BYTES = 8'h82;
    localparam logic [7:0] LEN_SIMPLE_EXT = 8'hFF;

    // BER tag fields.
    localparam logic [4:0] TAG_LOW_EXT = 5'h1F;

endpackage

`default_nettype wire

// File: rtl/core/tlv_byte_if.sv
// Handshake channel that carries one raw byte of the TLV buffer per item.
`default_nettype none

interface tlv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlv_result_if.sv
// Handshake channel that carries one parsed header, value byte or error per item.
`default_nettype none

interface tlv_result_if;
    import tlv_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       result_kind;
    logic [2:0]  tag_class;
    logic [7:0]  tag_number;
    logic [15:0] value_length;
    logic [7:0]  value_byte;
    logic        last;

    modport source (output valid, output result_kind, output tag_class, output tag_number,
                    output value_length, output value_byte, output last, input ready);
    modport sink   (input valid, input result_kind, input tag_class, input tag_number,
                    input value_length, input value_byte, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlv_stream_parser.sv
// Top level of the byte-serial BER/Simple TLV stream parser.
//
// The stream channel takes one raw byte per item, with end_of_data set on the
// final byte of a buffer. The result channel gives at most one item per byte:
// a header (class, tag, length), a value byte, a truncated-header error or an
// unsupported-length error. last marks the final value byte, or a header with
// no value bytes after it. The cfg_we/cfg_wdata port writes the mode bit
// (1 Simple-TLV, 0 BER-TLV); write it only while the parser is idle.
//
// A byte goes into the input register and its result then into the result
// register. One byte is taken every cycle while the receiver does not stall;
// the single pass through the phase logic between the two registers sets
// that rate. Padding bytes and bytes drained after a length error give no
// result but still pass through the input register.
//
// Reset clears the mode to BER, empties both registers and makes the parser
// wait for a tag byte. When the receiver stalls, the result register holds
// its item and the input register holds the next byte; stream.ready then
// drops until the result is taken.
`default_nettype none

module tlv_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    tlv_byte_if.sink         stream,
    tlv_result_if.source     result
);
    import tlv_pkg::*;

    // Configuration and input stage.
    logic        simple_mode_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [2:0]  class_reg, class_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] remain_reg, remain_next;

    // Result stage.
    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [2:0]  out_class_reg;
    logic [7:0]  out_tag_reg;
    logic [15:0] out_length_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    // Combinational result of the current byte.
    logic        advance;
    logic        emit;
    kind_t       kind_c;
    logic [15:0] out_length_c;
    logic [7:0]  out_byte_c;
    logic        out_last_c;
    logic        header_done;
    logic        no_value;
    logic [15:0] remain_dec;

    // The byte in the input register moves on when the result register is free.
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simple_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            simple_mode_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.data_byte;
            in_end_reg  <= stream.end_of_data;
        end
    end

    // Phase logic for one byte.
    always_comb
    begin
        phase_next   = phase_reg;
        class_next   = class_reg;
        tag_next     = tag_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        kind_c       = KIND_HEADER;
        out_length_c = '0;
        out_byte_c   = '0;
        out_last_c   = 1'b0;
        header_done  = 1'b0;
        no_value     = 1'b0;
        remain_dec   = remain_reg - 16'd1;

        case (phase_reg)
            PH_TAG:
            begin
                if (in_byte_reg != PAD_ZERO && in_byte_reg != PAD_ONES)
                begin
                    length_next = '0;
                    remain_next = '0;
                    if (simple_mode_reg)
                    begin
                        class_next = '0;
                        tag_next   = in_byte_reg;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        class_next = in_byte_reg[7:5];
                        if (in_byte_reg[4:0] == TAG_LOW_EXT)
                        begin
                            tag_next   = '0;
                            phase_next = PH_TAG2;
                        end
                        else
                        begin
                            tag_next   = {3'b000, in_byte_reg[4:0]};
                            phase_next = PH_LEN;
                        end
                    end
                end
            end
            PH_TAG2:
            begin
                tag_next   = {1'b0, in_byte_reg[6:0]};
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (simple_mode_reg)
                begin
                    if (in_byte_reg != LEN_SIMPLE_EXT)
                    begin
                        length_next = {8'h00, in_byte_reg};
                        header_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LENHI;
                    end
                end
                else if (!in_byte_reg[7])
                begin
                    length_next = {8'h00, in_byte_reg};
                    header_done = 1'b1;
                end
                else if (in_byte_reg == LEN_ONE_BYTE)
                begin
                    phase_next = PH_LEN1;
                end
                else if (in_byte_reg == LEN_TWO_BYTES)
                begin
                    phase_next = PH_LENHI;
                end
                else
                begin
                    emit       = 1'b1;
                    kind_c     = KIND_BADLEN;
                    phase_next = PH_DRAIN;
                end
            end
            PH_LEN1:
            begin
                length_next = {8'h00, in_byte_reg};
                header_done = 1'b1;
            end
            PH_LENHI:
            begin
                length_next = {in_byte_reg, 8'h00};
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                length_next = {length_reg[15:8], in_byte_reg};
                header_done = 1'b1;
            end
            PH_VALUE:
            begin
                remain_next  = remain_dec;
                emit         = 1'b1;
                kind_c       = KIND_VALUE;
                out_length_c = length_reg;
                out_byte_c   = in_byte_reg;
                out_last_c   = (remain_dec == '0) || in_end_reg;
                if (remain_dec == '0)
                begin
                    phase_next = PH_TAG;
                end
            end
            default:
            begin
                // Draining after a length error: the byte is dropped.
            end
        endcase

        // A complete header is emitted and opens the value bytes, if any follow.
        if (header_done)
        begin
            no_value     = (length_next == '0) || in_end_reg;
            emit         = 1'b1;
            kind_c       = KIND_HEADER;
            out_length_c = length_next;
            out_last_c   = no_value;
            remain_next  = length_next;
            phase_next   = no_value ? PH_TAG : PH_VALUE;
        end

        // End of data cuts any open header short and restarts at a tag.
        if (in_end_reg)
        begin
            if (!emit && phase_next != PH_TAG && phase_next != PH_DRAIN)
            begin
                emit         = 1'b1;
                kind_c       = KIND_TRUNC;
                out_length_c = '0;
                out_byte_c   = '0;
                out_last_c   = 1'b0;
            end
            phase_next  = PH_TAG;
            remain_next = '0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            class_reg  <= '0;
            tag_reg    <= '0;
            length_reg <= '0;
            remain_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            tag_reg    <= tag_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg       <= kind_c;
            out_class_reg  <= class_next;
            out_tag_reg    <= tag_next;
            out_length_reg <= out_length_c;
            out_byte_reg   <= out_byte_c;
            out_last_reg   <= out_last_c;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = kind_reg;
    assign result.tag_class    = out_class_reg;
    assign result.tag_number   = out_tag_reg;
    assign result.value_length = out_length_reg;
    assign result.value_byte   = out_byte_reg;
    assign result.last         = out_last_reg;

    // A header without its last mark always opens the value phase.
    a_header_opens_value: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && kind_c == KIND_HEADER && !out_last_c |=> phase_reg == PH_VALUE)
        else $error("header without last did not enter the value phase");

    // The value phase always has bytes left to deliver.
    a_value_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> remain_reg != '0)
        else $error("value phase entered with no bytes remaining");

    // Any byte carrying the end of data leaves the parser waiting for a tag.
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_end_reg |=> phase_reg == PH_TAG && remain_reg == '0)
        else $error("end of data did not return the parser to the tag phase");

    // A byte held in the input register is never lost while the result stalls.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte was dropped");

endmodule

`default_nettype wire

// File: test/tlv_stream_parser_test.sv
// Self-checking testbench for the BER/Simple TLV stream parser.
`default_nettype none

module tlv_stream_parser_test;
    import tlv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 80;

    // One parsed result as the block should produce it.
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  cls;
        logic [7:0]  tag;
        logic [15:0] len;
        logic [7:0]  vbyte;
        logic        last;
    } tlv_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    tlv_byte_if   stream_ch ();
    tlv_result_if result_ch ();

    tlv_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    // Parser state as the testbench tracks it.
    logic        p_simple    = 1'b0;
    phase_t      p_phase     = PH_TAG;
    logic [2:0]  p_cls       = 3'd0;
    logic [7:0]  p_tag       = 8'd0;
    logic [15:0] p_len       = 16'd0;
    logic [15:0] p_remaining = 16'd0;

    tlv_result_t pending_results[$];
    logic [7:0]  tlv_buf[$];

    int fail_count        = 0;
    int idle_cycles       = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    logic hold_off        = 1'b0;

    // Clock with a 12-unit period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Builds a result from the current class and tag.
    function automatic tlv_result_t make_result(kind_t kind, logic [15:0] len,
                                                logic [7:0] vbyte, logic last);
        tlv_result_t r;
        r.kind  = kind;
        r.cls   = p_cls;
        r.tag   = p_tag;
        r.len   = len;
        r.vbyte = vbyte;
        r.last  = last;
        return r;
    endfunction

    // A complete header: emit it and move to the value bytes if any follow.
    function automatic tlv_result_t header_result(logic eod);
        logic none;
        none        = (p_len == 16'd0) || eod;
        p_remaining = p_len;
        p_phase     = none ? PH_TAG : PH_VALUE;
        return make_result(KIND_HEADER, p_len, 8'd0, none);
    endfunction

    // Advances the tracked parser by one byte and queues the result it causes.
    function automatic void parse_byte(logic [7:0] b, logic eod);
        tlv_result_t r;
        logic        got;
        got = 1'b0;
        r   = '0;
        case (p_phase)
            PH_TAG:
            begin
                if (b != PAD_ZERO && b != PAD_ONES)
                begin
                    p_len       = 16'd0;
                    p_remaining = 16'd0;
                    if (p_simple)
                    begin
                        p_cls   = 3'd0;
                        p_tag   = b;
                        p_phase = PH_LEN;
                    end
                    else
                    begin
                        p_cls = b[7:5];
                        if (b[4:0] == TAG_LOW_EXT)
                        begin
                            p_tag   = 8'd0;
                            p_phase = PH_TAG2;
                        end
                        else
                        begin
                            p_tag   = {3'd0, b[4:0]};
                            p_phase = PH_LEN;
                        end
                    end
                end
            end
            PH_TAG2:
            begin
                p_tag   = {1'b0, b[6:0]};
                p_phase = PH_LEN;
            end
            PH_LEN:
            begin
                if (p_simple)
                begin
                    if (b != LEN_SIMPLE_EXT)
                    begin
                        p_len = {8'd0, b};
                        r     = header_result(eod);
                        got   = 1'b1;
                    end
                    else
                        p_phase = PH_LENHI;
                end
                else if (!b[7])
                begin
                    p_len = {8'd0, b};
                    r     = header_result(eod);
                    got   = 1'b1;
                end
                else if (b == LEN_ONE_BYTE)
                    p_phase = PH_LEN1;
                else if (b == LEN_TWO_BYTES)
                    p_phase = PH_LENHI;
                else
                begin
                    r       = make_result(KIND_BADLEN, 16'd0, 8'd0, 1'b0);
                    got     = 1'b1;
                    p_phase = PH_DRAIN;
                end
            end
            PH_LEN1:
            begin
                p_len = {8'd0, b};
                r     = header_result(eod);
                got   = 1'b1;
            end
            PH_LENHI:
            begin
                p_len   = {b, 8'd0};
                p_phase = PH_LENLO;
            end
            PH_LENLO:
            begin
                p_len = {p_len[15:8], b};
                r     = header_result(eod);
                got   = 1'b1;
            end
            PH_VALUE:
            begin
                p_remaining = p_remaining - 16'd1;
                r   = make_result(KIND_VALUE, p_len, b, (p_remaining == 16'd0) || eod);
                got = 1'b1;
                if (p_remaining == 16'd0)
                    p_phase = PH_TAG;
            end
            default:
            begin
            end
        endcase

        // End of data cuts the item short; a cut-off header is an error.
        if (eod)
        begin
            if (!got && p_phase != PH_TAG && p_phase != PH_DRAIN)
            begin
                r   = make_result(KIND_TRUNC, 16'd0, 8'd0, 1'b0);
                got = 1'b1;
            end
            p_phase     = PH_TAG;
            p_remaining = 16'd0;
        end

        if (got)
            pending_results.push_back(r);
    endfunction

    // Offers one byte, with random idle cycles first, until the parser takes it.
    task automatic send_byte(logic [7:0] b, logic eod);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            stream_ch.valid = 1'b0;
            @(negedge clk);
        end
        stream_ch.valid       = 1'b1;
        stream_ch.data_byte   = b;
        stream_ch.end_of_data = eod;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        parse_byte(b, eod);
    endtask

    // Sends the buffer with end of data on its final byte.
    task automatic send_buffer();
        foreach (tlv_buf[i])
            send_byte(tlv_buf[i], i == tlv_buf.size() - 1);
    endtask

    // Writes the mode bit once the parser has gone quiet.
    task automatic set_mode(logic mode);
        @(negedge clk);
        stream_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        cfg_we    = 1'b0;
        p_simple  = mode;
    endtask

    // Fills the buffer with random TLV items for the current mode, sometimes
    // with padding, bad lengths, noise or a cut at a random point.
    task automatic make_buffer();
        int          n_tlv;
        int          len;
        int          r;
        int          cut;
        logic [7:0]  t;
        logic [15:0] l16;
        tlv_buf.delete();
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 8)) tlv_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_tlv = $urandom_range(1, 4);
        repeat (n_tlv)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    tlv_buf.push_back($urandom_range(0, 1) ? PAD_ONES : PAD_ZERO);
            r   = $urandom_range(0, 99);
            len = (r < 70) ? $urandom_range(0, 6) :
                  (r < 95) ? $urandom_range(7, 40) : $urandom_range(41, 300);
            l16 = 16'(len);
            r   = $urandom_range(0, 99);
            if (p_simple)
            begin
                tlv_buf.push_back(8'($urandom_range(1, 254)));
                if (len < 255 && r < 75)
                    tlv_buf.push_back(l16[7:0]);
                else
                begin
                    tlv_buf.push_back(LEN_SIMPLE_EXT);
                    tlv_buf.push_back(l16[15:8]);
                    tlv_buf.push_back(l16[7:0]);
                end
            end
            else
            begin
                t = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    t[4:0] = TAG_LOW_EXT;
                if (t == PAD_ZERO || t == PAD_ONES)
                    t = t ^ 8'h20;
                tlv_buf.push_back(t);
                if (t[4:0] == TAG_LOW_EXT)
                    tlv_buf.push_back(8'($urandom_range(0, 255)));
                if (r < 5)
                begin
                    // Unsupported long form; what follows is drained.
                    t = 8'($urandom_range(128, 255));
                    if (t == LEN_ONE_BYTE || t == LEN_TWO_BYTES)
                        t = 8'h80;
                    tlv_buf.push_back(t);
                    len = $urandom_range(0, 4);
                end
                else if (len < 128 && r < 60)
                    tlv_buf.push_back(l16[7:0]);
                else if (len < 256 && r < 80)
                begin
                    tlv_buf.push_back(LEN_ONE_BYTE);
                    tlv_buf.push_back(l16[7:0]);
                end
                else
                begin
                    tlv_buf.push_back(LEN_TWO_BYTES);
                    tlv_buf.push_back(l16[15:8]);
                    tlv_buf.push_back(l16[7:0]);
                end
            end
            repeat (len) tlv_buf.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, tlv_buf.size());
            while (tlv_buf.size() > cut)
                void'(tlv_buf.pop_back());
        end
    endtask

    // BER coding: padding, long tags, every length form and the error cases.
    task automatic test_directed_ber();
        set_mode(1'b0);
        tlv_buf = '{8'h00, 8'hFF, 8'h5A, 8'h01, 8'hC3};
        send_buffer();
        // Only padding before the end of data.
        tlv_buf = '{8'hFF, 8'h00};
        send_buffer();
        // Two-byte tag, bit 7 of the second byte dropped, zero length.
        tlv_buf = '{8'h3F, 8'hFF, 8'h00};
        send_buffer();
        // Length 0x80 is not supported; the rest of the buffer is drained.
        tlv_buf = '{8'hE1, 8'h80, 8'h11, 8'h22};
        send_buffer();
        // Header cut off inside the length.
        tlv_buf = '{8'h02, 8'h82};
        send_buffer();
        // Largest length, header on the final byte.
        tlv_buf = '{8'h04, 8'h82, 8'hFF, 8'hFF};
        send_buffer();
        // Value cut off after one byte.
        tlv_buf = '{8'h05, 8'h81, 8'h03, 8'hAA};
        send_buffer();
    endtask

    // Simple coding: one-byte tag and the three-byte length form.
    task automatic test_directed_simple();
        set_mode(1'b1);
        tlv_buf = '{8'hFE, 8'hFF, 8'h00, 8'h02, 8'hAB, 8'hCD};
        send_buffer();
    endtask

    // Random buffers with the given idling, changing the mode now and then.
    task automatic test_random(int src_idle, int rcv_idle, int n_bytes);
        int sent;
        sent              = 0;
        sender_idle_pct   = src_idle;
        receiver_idle_pct = rcv_idle;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 9) == 0)
                set_mode(1'($urandom_range(0, 1)));
            make_buffer();
            sent += tlv_buf.size();
            send_buffer();
        end
    endtask

    // The receiver holds off while the sender keeps offering bytes.
    task automatic test_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (6)
                begin
                    make_buffer();
                    send_buffer();
                end
            end
        join
    endtask

    // Receiver ready, changed at the falling edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = !hold_off && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Compare each result item with the oldest expected one.
    always @(posedge clk)
    begin
        tlv_result_t got;
        tlv_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.kind  = result_ch.result_kind;
            got.cls   = result_ch.tag_class;
            got.tag   = result_ch.tag_number;
            got.len   = result_ch.value_length;
            got.vbyte = result_ch.value_byte;
            got.last  = result_ch.last;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result kind %0d class %0d tag %0h len %0d byte %0h last %0d",
                         $time, got.kind, got.cls, got.tag, got.len, got.vbyte, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    $display("%0t: mismatch expected kind %0d class %0d tag %0h len %0d byte %0h last %0d",
                             $time, want.kind, want.cls, want.tag, want.len, want.vbyte,
                             want.last);
                    $display("%0t:          actual kind %0d class %0d tag %0h len %0d byte %0h last %0d",
                             $time, got.kind, got.cls, got.tag, got.len, got.vbyte, got.last);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 1'b0;
        stream_ch.valid       = 1'b0;
        stream_ch.data_byte   = 8'd0;
        stream_ch.end_of_data = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct   = 37;
        receiver_idle_pct = 70;
        test_directed_ber();
        test_directed_simple();
        test_random(37, 70, 400);
        test_random(70, 37, 400);
        test_backpressure();
        test_random(0, 0, 400);

        // Let the last results come out.
        @(negedge clk);
        stream_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/tlv_pkg.sv
rtl/core/tlv_byte_if.sv
rtl/core/tlv_result_if.sv
rtl/core/tlv_stream_parser.sv
test/tlv_stream_parser_test.sv
